FILE: hdl/dds_pkg.sv
// Shared types and constants for the dataflow dispatch scheduler.
// Used by every module of the block except dds_ram; depends on nothing.
package dds_pkg;

  localparam int MAX_NODES   = 64;
  localparam int MAX_FANOUT  = 16;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int FAN_W       = $clog2(MAX_FANOUT);
  localparam int CNT_W       = NODE_W + 1;
  localparam int SC_W        = FAN_W + 1;
  localparam int PP_W        = 7;
  localparam int PP_MAX      = 127;
  localparam int RESULT_CAP  = 64;
  localparam int STORE_DEPTH = MAX_NODES * MAX_FANOUT;

  // Input item modes
  typedef enum logic [2:0] {
    MODE_EDGE     = 3'd0,
    MODE_START    = 3'd1,
    MODE_OK       = 3'd2,
    MODE_FAIL     = 3'd3,
    MODE_DEADLINE = 3'd4,
    MODE_CLEAR    = 3'd5,
    MODE_BAD      = 3'd6
  } mode_t;

  // Latched error causes
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FAIL     = 2'd1,
    ERR_DEADLINE = 2'd2
  } err_t;

  // Classified command handed from front to back
  typedef struct packed {
    mode_t              op;
    logic [NODE_W-1:0]  node;
    logic [NODE_W-1:0]  succ;
    logic               node_ok;
    logic               succ_ok;
    logic [CNT_W-1:0]   count;
  } cmd_t;

  // One result transaction
  typedef struct packed {
    logic               strobe;
    logic               kind;
    logic [NODE_W-1:0]  dnode;
    logic               last;
    logic [CNT_W-1:0]   in_flight;
    logic               finished;
    err_t               err;
    logic               rej;
  } res_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    B_IDLE,
    B_DECODE,
    B_EDGE_WR,
    B_SCAN_RD,
    B_SCAN_CHK,
    B_WALK_CNTD,
    B_WALK_SRD,
    B_WALK_PRD,
    B_WALK_UPD,
    B_DISP,
    B_DISP_EMIT,
    B_STATUS
  } bstate_t;

endpackage

FILE: hdl/dds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module dds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/dds_front.sv
// Front end: holds node_count, accepts items and classifies them.
// Depends on dds_pkg.
module dds_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [2:0]                  mode,
  input  logic [dds_pkg::NODE_W-1:0]  node,
  input  logic [dds_pkg::NODE_W-1:0]  successor,
  input  logic                        cfg_valid,
  input  logic [dds_pkg::CNT_W-1:0]   cfg_data,
  output logic                        cfg_ready,
  input  logic                        q_full,
  output logic                        push,
  output dds_pkg::cmd_t               cmd
);

  logic [dds_pkg::CNT_W-1:0] node_count;
  logic [dds_pkg::CNT_W-1:0] count;

  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      node_count <= cfg_data;
    end
  end

  // Counts above the node limit act as the limit
  assign count = (node_count > dds_pkg::CNT_W'(dds_pkg::MAX_NODES)) ?
                 dds_pkg::CNT_W'(dds_pkg::MAX_NODES) : node_count;

  assign push = start && !q_full;

  // Classify mode and range-check indexes
  always_comb begin
    case (mode)
      dds_pkg::MODE_EDGE:     cmd.op = dds_pkg::MODE_EDGE;
      dds_pkg::MODE_START:    cmd.op = dds_pkg::MODE_START;
      dds_pkg::MODE_OK:       cmd.op = dds_pkg::MODE_OK;
      dds_pkg::MODE_FAIL:     cmd.op = dds_pkg::MODE_FAIL;
      dds_pkg::MODE_DEADLINE: cmd.op = dds_pkg::MODE_DEADLINE;
      dds_pkg::MODE_CLEAR:    cmd.op = dds_pkg::MODE_CLEAR;
      default:                cmd.op = dds_pkg::MODE_BAD;
    endcase
    cmd.node    = node;
    cmd.succ    = successor;
    cmd.node_ok = {1'b0, node} < count;
    cmd.succ_ok = {1'b0, successor} < count;
    cmd.count   = count;
  end

endmodule

FILE: hdl/dds_cmdq.sv
// Two-entry command queue between front and back ends.
// Depends on dds_pkg.
module dds_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dds_pkg::cmd_t wdata,
  input  logic          pop,
  output dds_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  dds_pkg::cmd_t entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] used;

  assign full  = (used == 2'd2);
  assign empty = (used == 2'd0);
  assign head  = entry[rptr];

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= wdata;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      used <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      used <= used + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: hdl/dds_back.sv
// Back end: sequencer that executes commands against the graph state.
// Depends on dds_pkg and dds_ram.
module dds_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  dds_pkg::cmd_t q_head,
  output logic          pop,
  output dds_pkg::res_t res
);

  localparam int NW = dds_pkg::NODE_W;
  localparam int CW = dds_pkg::CNT_W;
  localparam int SW = dds_pkg::SC_W;
  localparam int PW = dds_pkg::PP_W;
  localparam int AW = $clog2(dds_pkg::STORE_DEPTH);

  dds_pkg::bstate_t state, state_next;
  dds_pkg::cmd_t    cmd, cmd_next;
  dds_pkg::err_t    err, err_next;
  dds_pkg::res_t    res_next;
  logic             started, started_next;
  logic             rej, rej_next;
  logic [CW-1:0]    inflight, inflight_next;
  logic [NW-1:0]    head, head_next;
  logic [CW-1:0]    fill, fill_next;
  logic [dds_pkg::MAX_NODES-1:0] running, running_next;
  logic [dds_pkg::MAX_NODES-1:0] pp_vld, pp_vld_next;
  logic [dds_pkg::MAX_NODES-1:0] sc_vld, sc_vld_next;
  logic [CW-1:0]    idx, idx_next;
  logic [SW-1:0]    wi, wi_next;
  logic [SW-1:0]    wm, wm_next;
  logic [NW-1:0]    child, child_next;
  logic [CW-1:0]    disp_cnt, disp_cnt_next;

  // RAM ports
  logic          pp_we, sc_we, st_we, ff_we;
  logic [NW-1:0] pp_waddr, pp_raddr, sc_waddr, sc_raddr, ff_waddr, ff_raddr;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [PW-1:0] pp_wdata, pp_rd, pp_val;
  logic [SW-1:0] sc_wdata, sc_rd, sc_val;
  logic [NW-1:0] st_wdata, st_rd, ff_wdata, ff_rd;
  logic          pp_vq, sc_vq;
  logic          push_en;
  logic [NW-1:0] push_node;

  dds_ram #(.WIDTH(PW), .DEPTH(dds_pkg::MAX_NODES)) u_pending (
    .clk(clk), .we(pp_we), .waddr(pp_waddr), .wdata(pp_wdata),
    .raddr(pp_raddr), .rdata(pp_rd));

  dds_ram #(.WIDTH(SW), .DEPTH(dds_pkg::MAX_NODES)) u_succ_cnt (
    .clk(clk), .we(sc_we), .waddr(sc_waddr), .wdata(sc_wdata),
    .raddr(sc_raddr), .rdata(sc_rd));

  dds_ram #(.WIDTH(NW), .DEPTH(dds_pkg::STORE_DEPTH)) u_succ_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rd));

  dds_ram #(.WIDTH(NW), .DEPTH(dds_pkg::MAX_NODES)) u_ready_fifo (
    .clk(clk), .we(ff_we), .waddr(ff_waddr), .wdata(ff_wdata),
    .raddr(ff_raddr), .rdata(ff_rd));

  // Entries never written since clear read as zero
  assign pp_val = pp_vq ? pp_rd : '0;
  assign sc_val = sc_vq ? sc_rd : '0;

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dds_pkg::B_IDLE;
      err      <= dds_pkg::ERR_NONE;
      started  <= 1'b0;
      inflight <= '0;
      head     <= '0;
      fill     <= '0;
      running  <= '0;
      pp_vld   <= '0;
      sc_vld   <= '0;
      res      <= '0;
    end else begin
      state    <= state_next;
      err      <= err_next;
      started  <= started_next;
      inflight <= inflight_next;
      head     <= head_next;
      fill     <= fill_next;
      running  <= running_next;
      pp_vld   <= pp_vld_next;
      sc_vld   <= sc_vld_next;
      res      <= res_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    rej      <= rej_next;
    idx      <= idx_next;
    wi       <= wi_next;
    wm       <= wm_next;
    child    <= child_next;
    disp_cnt <= disp_cnt_next;
    pp_vq    <= pp_vld[pp_raddr];
    sc_vq    <= sc_vld[sc_raddr];
  end

  // Sequencer
  always_comb begin
    state_next    = state;
    cmd_next      = cmd;
    err_next      = err;
    started_next  = started;
    rej_next      = rej;
    inflight_next = inflight;
    head_next     = head;
    fill_next     = fill;
    running_next  = running;
    pp_vld_next   = pp_vld;
    sc_vld_next   = sc_vld;
    idx_next      = idx;
    wi_next       = wi;
    wm_next       = wm;
    child_next    = child;
    disp_cnt_next = disp_cnt;
    res_next      = res;
    res_next.strobe = 1'b0;
    pop       = 1'b0;
    pp_we     = 1'b0;
    pp_waddr  = '0;
    pp_wdata  = '0;
    pp_raddr  = '0;
    sc_we     = 1'b0;
    sc_waddr  = '0;
    sc_wdata  = '0;
    sc_raddr  = '0;
    st_we     = 1'b0;
    st_waddr  = '0;
    st_wdata  = '0;
    st_raddr  = '0;
    ff_we     = 1'b0;
    ff_waddr  = '0;
    ff_wdata  = '0;
    ff_raddr  = '0;
    push_en   = 1'b0;
    push_node = '0;

    case (state)
      dds_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          cmd_next   = q_head;
          state_next = dds_pkg::B_DECODE;
        end
      end

      dds_pkg::B_DECODE: begin
        disp_cnt_next = '0;
        rej_next      = 1'b0;
        state_next    = dds_pkg::B_STATUS;
        case (cmd.op)
          dds_pkg::MODE_EDGE: begin
            sc_raddr   = cmd.node;
            pp_raddr   = cmd.succ;
            state_next = dds_pkg::B_EDGE_WR;
          end
          dds_pkg::MODE_START: begin
            if (started) begin
              rej_next = 1'b1;
            end else begin
              started_next = 1'b1;
              idx_next     = '0;
              state_next   = (cmd.count == '0) ? dds_pkg::B_DISP : dds_pkg::B_SCAN_RD;
            end
          end
          dds_pkg::MODE_OK, dds_pkg::MODE_FAIL: begin
            if (!started || !cmd.node_ok || !running[cmd.node]) begin
              rej_next = 1'b1;
            end else begin
              running_next[cmd.node] = 1'b0;
              if (inflight != '0) inflight_next = inflight - 1'b1;
              if (cmd.op == dds_pkg::MODE_FAIL) begin
                if (err == dds_pkg::ERR_NONE) err_next = dds_pkg::ERR_FAIL;
              end else begin
                sc_raddr   = cmd.node;
                state_next = dds_pkg::B_WALK_CNTD;
              end
            end
          end
          dds_pkg::MODE_DEADLINE: begin
            if (err == dds_pkg::ERR_NONE) err_next = dds_pkg::ERR_DEADLINE;
          end
          dds_pkg::MODE_CLEAR: begin
            started_next  = 1'b0;
            err_next      = dds_pkg::ERR_NONE;
            inflight_next = '0;
            head_next     = '0;
            fill_next     = '0;
            running_next  = '0;
            pp_vld_next   = '0;
            sc_vld_next   = '0;
          end
          default: rej_next = 1'b1;
        endcase
      end

      // Edge load: check then append to successor list
      dds_pkg::B_EDGE_WR: begin
        state_next = dds_pkg::B_STATUS;
        if (started || !cmd.node_ok || !cmd.succ_ok ||
            sc_val >= SW'(dds_pkg::MAX_FANOUT) || pp_val >= PW'(dds_pkg::PP_MAX)) begin
          rej_next = 1'b1;
        end else begin
          st_we    = 1'b1;
          st_waddr = {cmd.node, sc_val[dds_pkg::FAN_W-1:0]};
          st_wdata = cmd.succ;
          sc_we    = 1'b1;
          sc_waddr = cmd.node;
          sc_wdata = sc_val + 1'b1;
          sc_vld_next[cmd.node] = 1'b1;
          pp_we    = 1'b1;
          pp_waddr = cmd.succ;
          pp_wdata = pp_val + 1'b1;
          pp_vld_next[cmd.succ] = 1'b1;
        end
      end

      // Start: queue nodes with no pending parent, in index order
      dds_pkg::B_SCAN_RD: begin
        pp_raddr   = idx[NW-1:0];
        state_next = dds_pkg::B_SCAN_CHK;
      end

      dds_pkg::B_SCAN_CHK: begin
        if (pp_val == '0) begin
          push_en   = 1'b1;
          push_node = idx[NW-1:0];
        end
        idx_next   = idx + 1'b1;
        state_next = (idx + 1'b1 == cmd.count) ? dds_pkg::B_DISP : dds_pkg::B_SCAN_RD;
      end

      // Success: walk the successor list
      dds_pkg::B_WALK_CNTD: begin
        wm_next    = sc_val;
        wi_next    = '0;
        state_next = (sc_val == '0) ? dds_pkg::B_DISP : dds_pkg::B_WALK_SRD;
      end

      dds_pkg::B_WALK_SRD: begin
        st_raddr   = {cmd.node, wi[dds_pkg::FAN_W-1:0]};
        state_next = dds_pkg::B_WALK_PRD;
      end

      dds_pkg::B_WALK_PRD: begin
        child_next = st_rd;
        pp_raddr   = st_rd;
        state_next = dds_pkg::B_WALK_UPD;
      end

      dds_pkg::B_WALK_UPD: begin
        if (pp_val != '0) begin
          pp_we    = 1'b1;
          pp_waddr = child;
          pp_wdata = pp_val - 1'b1;
          pp_vld_next[child] = 1'b1;
          if (pp_val == PW'(1)) begin
            push_en   = 1'b1;
            push_node = child;
          end
        end
        wi_next    = wi + 1'b1;
        state_next = (wi + 1'b1 == wm) ? dds_pkg::B_DISP : dds_pkg::B_WALK_SRD;
      end

      // Dispatch loop
      dds_pkg::B_DISP: begin
        if (disp_cnt < CW'(dds_pkg::RESULT_CAP) && fill != '0 &&
            err == dds_pkg::ERR_NONE) begin
          ff_raddr   = head;
          state_next = dds_pkg::B_DISP_EMIT;
        end else if (disp_cnt == '0) begin
          state_next = dds_pkg::B_STATUS;
        end else begin
          state_next = dds_pkg::B_IDLE;
        end
      end

      dds_pkg::B_DISP_EMIT: begin
        running_next[ff_rd] = 1'b1;
        inflight_next       = inflight + 1'b1;
        head_next           = head + 1'b1;
        fill_next           = fill - 1'b1;
        disp_cnt_next       = disp_cnt + 1'b1;
        res_next.strobe     = 1'b1;
        res_next.kind       = 1'b1;
        res_next.dnode      = ff_rd;
        res_next.last       = !((disp_cnt + 1'b1) < CW'(dds_pkg::RESULT_CAP) &&
                                fill != CW'(1));
        res_next.in_flight  = inflight + 1'b1;
        res_next.finished   = 1'b0;
        res_next.err        = err;
        res_next.rej        = 1'b0;
        state_next          = dds_pkg::B_DISP;
      end

      dds_pkg::B_STATUS: begin
        res_next.strobe    = 1'b1;
        res_next.kind      = 1'b0;
        res_next.dnode     = '0;
        res_next.last      = 1'b1;
        res_next.in_flight = inflight;
        res_next.finished  = started && (inflight == '0);
        res_next.err       = err;
        res_next.rej       = rej;
        state_next         = dds_pkg::B_IDLE;
      end

      default: state_next = dds_pkg::B_IDLE;
    endcase

    // Ready FIFO push
    if (push_en && fill < CW'(dds_pkg::MAX_NODES)) begin
      ff_we     = 1'b1;
      ff_waddr  = head + fill[NW-1:0];
      ff_wdata  = push_node;
      fill_next = fill + 1'b1;
    end
  end

endmodule

FILE: hdl/dag_dependency_dispatch_scheduler.sv
// Dataflow task-graph scheduler top level: front end, command queue, back end.
// Sequencing: a status result is registered after decode; an edge load first reads its counts;
// a start scans the nodes one at a time, a success report walks its successors one at a time,
// and each dispatch result comes from a read state followed by an emit state.
// Throughput: one item at a time in the back-end sequencer; busy rises when the 2-entry
// command queue is full. Results carry a one-cycle strobe and cannot be stalled.
// Reset (rst, synchronous) clears all control state at once; no clearing pass.
module dag_dependency_dispatch_scheduler (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  mode,
  input  logic [dds_pkg::NODE_W-1:0]  node,
  input  logic [dds_pkg::NODE_W-1:0]  successor,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [dds_pkg::CNT_W-1:0]   cfg_data,
  output logic                        strobe,
  output logic                        kind,
  output logic [dds_pkg::NODE_W-1:0]  dispatched_node,
  output logic                        last,
  output logic [dds_pkg::CNT_W-1:0]   in_flight,
  output logic                        finished,
  output logic [1:0]                  error_cause,
  output logic                        rejected
);

  dds_pkg::cmd_t fe_cmd, q_head;
  dds_pkg::res_t res;
  logic          fe_push, q_full, q_empty, q_pop;

  dds_front u_front (
    .clk(clk), .rst(rst), .start(start), .mode(mode), .node(node),
    .successor(successor), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .cfg_ready(cfg_ready), .q_full(q_full), .push(fe_push), .cmd(fe_cmd));

  dds_cmdq u_cmdq (
    .clk(clk), .rst(rst), .push(fe_push), .wdata(fe_cmd), .pop(q_pop),
    .head(q_head), .full(q_full), .empty(q_empty));

  dds_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_head(q_head), .pop(q_pop),
    .res(res));

  assign busy            = q_full;
  assign strobe          = res.strobe;
  assign kind            = res.kind;
  assign dispatched_node = res.dnode;
  assign last            = res.last;
  assign in_flight       = res.in_flight;
  assign finished        = res.finished;
  assign error_cause     = res.err;
  assign rejected        = res.rej;

endmodule

FILE: hdl/dds_checker.sv
// Port-level checks on the scheduler's result stream, bound to the top level.
// Depends on dds_pkg for widths.
module dds_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       strobe,
  input logic                       kind,
  input logic                       last,
  input logic [dds_pkg::CNT_W-1:0]  in_flight,
  input logic                       finished,
  input logic                       rejected
);

  // A dispatch is never a rejection and leaves a node in flight
  a_disp_ok: assert property (@(posedge clk) disable iff (rst)
    strobe && kind |-> !rejected && in_flight != '0)
    else $error("dispatch flagged rejected or with nothing in flight");

  // A status result is always the only one of its item
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !kind |-> last)
    else $error("status result without last mark");

  // A dispatch burst continues after a gap with no strobe
  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && kind && !last |=> !strobe ##1 (strobe && kind))
    else $error("dispatch burst broken");

  // Finished only with nothing in flight
  a_finished: assert property (@(posedge clk) disable iff (rst)
    strobe && finished |-> in_flight == '0)
    else $error("finished with nodes in flight");

endmodule

bind dag_dependency_dispatch_scheduler dds_checker u_dds_checker (
  .clk(clk), .rst(rst), .strobe(strobe), .kind(kind), .last(last),
  .in_flight(in_flight), .finished(finished), .rejected(rejected));
